// File: rtl/cvsd_pkg.sv
// Shared types and constants for the CAN vehicle state decoder.
// Depends on nothing; used by can_vehicle_state_decoder.
package cvsd_pkg;

	localparam int unsigned IdW = 11;
	localparam int unsigned LenW = 4;
	localparam int unsigned PayloadW = 64;
	localparam int unsigned BitPosW = 6;
	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned InDataW = 80;
	localparam int unsigned OutDataW = 144;

	localparam logic [IdW-1:0] DETAIL_FRAME_ID = 11'h420;
	localparam logic [7:0] DETAIL_RESET = 8'hC4;
	localparam logic [7:0] SUB_TRACK_SPORT = 8'h11;
	localparam logic [LenW-1:0] LEN_DRIVE = 4'd7;
	localparam logic [LenW-1:0] LEN_FULL = 4'd8;
	localparam logic [LenW-1:0] LEN_STAB = 4'd2;

	localparam logic [IdW-1:0] AWD_ID_RESET = 11'd432;
	localparam logic [IdW-1:0] MODE_BUTTON_ID_RESET = 11'd773;
	localparam logic [IdW-1:0] BODY_ID_RESET = 11'd608;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_SPORT  = 2'd1,
		MODE_DRIFT  = 2'd2,
		MODE_TRACK  = 2'd3
	} veh_mode_t;

	localparam logic [1:0] STAB_ON = 2'd0;
	localparam logic [1:0] STAB_SPORT = 2'd1;
	localparam logic [1:0] STAB_OFF = 2'd2;

	localparam logic [3:0] NIB_NORMAL = 4'd0;
	localparam logic [3:0] NIB_SPORT = 4'd1;
	localparam logic [3:0] NIB_DRIFT = 4'd2;

	localparam logic [1:0] RAW_ON = 2'd0;
	localparam logic [1:0] RAW_OFF = 2'd1;
	localparam logic [1:0] RAW_SPORT = 2'd2;

	typedef enum logic [CfgIndexW-1:0] {
		REG_AWD_ID         = 3'd0,
		REG_STAB_ID        = 3'd1,
		REG_MODE_BUTTON_ID = 3'd2,
		REG_BODY_ID        = 3'd3,
		REG_DIAG_ID        = 3'd4,
		REG_MODE_BUTTON_BIT = 3'd5,
		REG_STAB_BUTTON_BIT = 3'd6,
		REG_STOP_START_BIT = 3'd7
	} cfg_reg_t;

endpackage

// File: rtl/can_vehicle_state_decoder.sv
// Top level of the CAN vehicle state decoder: input register, decode logic
// and the state registers that form the result. Depends on cvsd_pkg.
//
// Usage: received frames enter on the s_ channel, one item per frame, with
// s_tdata holding identifier, length and payload. Every item yields exactly
// one result item on the m_ channel: the complete tracked state after the
// frame was applied, with m_tuser flagging a diagnostic response.
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data while the block is idle; cfg_ready is always high.
// After an item is accepted, the input register holds it while the decode
// logic computes the new state, which the state registers load once the
// output may advance (no result waiting, or m_tready high).
// Throughput is one item per cycle while m_tready is high, set by the single
// decode stage whose state registers also serve as the result register.
// Reset clears the state to normal drive mode, stability on, detail 0xC4,
// no captured templates, and loads the register reset identifiers.
// When the receiver stalls, the result holds, the input register holds its
// item, and s_tready drops once that register is occupied.
module can_vehicle_state_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// frame_id[10:0], frame_length[14:11], payload[78:15], zero fill.
	input  logic [cvsd_pkg::InDataW-1:0]   s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// drive_mode[1:0], stability_mode[3:2], mode_detail[11:4],
	// mode_template[75:12], mode_template_valid[76], body_template[140:77],
	// body_template_valid[141], zero fill.
	output logic [cvsd_pkg::OutDataW-1:0]  m_tdata,
	// forward_to_diag[0].
	output logic                           m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cvsd_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [cvsd_pkg::IdW-1:0]       cfg_data
);

	logic [cvsd_pkg::IdW-1:0] awd_id_q, stab_id_q, mbtn_id_q, body_id_q, diag_id_q;
	logic [cvsd_pkg::BitPosW-1:0] mbtn_bit_q, sbtn_bit_q, ssbtn_bit_q;

	logic valid_s1;
	logic [cvsd_pkg::IdW-1:0] id_s1;
	logic [cvsd_pkg::LenW-1:0] len_s1;
	logic [cvsd_pkg::PayloadW-1:0] payload_s1;

	logic out_valid_q;
	logic [1:0] mode_q, stab_q;
	logic [7:0] detail_q;
	logic [cvsd_pkg::PayloadW-1:0] mtpl_q, btpl_q;
	logic mseen_q, bseen_q, fwd_q;

	logic advance, load_s1;
	logic [1:0] mode_d, stab_d;
	logic [7:0] detail_d;
	logic mcap, bcap, fwd_d;
	logic [7:0] byte1, byte4, byte6, byte7;
	logic [3:0] nib;
	logic [1:0] raw;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign load_s1 = s_tvalid && s_tready;

	assign byte1 = payload_s1[15:8];
	assign byte4 = payload_s1[39:32];
	assign byte6 = payload_s1[55:48];
	assign byte7 = payload_s1[63:56];
	assign nib = byte6[7:4];
	assign raw = byte1[5:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awd_id_q <= cvsd_pkg::AWD_ID_RESET;
			stab_id_q <= '0;
			mbtn_id_q <= cvsd_pkg::MODE_BUTTON_ID_RESET;
			body_id_q <= cvsd_pkg::BODY_ID_RESET;
			diag_id_q <= '0;
			mbtn_bit_q <= '0;
			sbtn_bit_q <= '0;
			ssbtn_bit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cvsd_pkg::cfg_reg_t'(cfg_index))
				cvsd_pkg::REG_AWD_ID: awd_id_q <= cfg_data;
				cvsd_pkg::REG_STAB_ID: stab_id_q <= cfg_data;
				cvsd_pkg::REG_MODE_BUTTON_ID: mbtn_id_q <= cfg_data;
				cvsd_pkg::REG_BODY_ID: body_id_q <= cfg_data;
				cvsd_pkg::REG_DIAG_ID: diag_id_q <= cfg_data;
				cvsd_pkg::REG_MODE_BUTTON_BIT: mbtn_bit_q <= cfg_data[cvsd_pkg::BitPosW-1:0];
				cvsd_pkg::REG_STAB_BUTTON_BIT: sbtn_bit_q <= cfg_data[cvsd_pkg::BitPosW-1:0];
				cvsd_pkg::REG_STOP_START_BIT: ssbtn_bit_q <= cfg_data[cvsd_pkg::BitPosW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			id_s1 <= s_tdata[10:0];
			len_s1 <= s_tdata[14:11];
			payload_s1 <= s_tdata[78:15];
		end
	end

	always_comb begin
		mode_d = mode_q;
		stab_d = stab_q;
		detail_d = detail_q;
		mcap = 1'b0;
		bcap = 1'b0;
		fwd_d = 1'b0;
		priority if (id_s1 == awd_id_q) begin
			if (len_s1 >= cvsd_pkg::LEN_DRIVE && byte4 == 8'h00) begin
				if (nib == cvsd_pkg::NIB_NORMAL) begin
					mode_d = cvsd_pkg::MODE_NORMAL;
				end else if (nib == cvsd_pkg::NIB_SPORT) begin
					mode_d = detail_q[0] ? cvsd_pkg::MODE_TRACK : cvsd_pkg::MODE_SPORT;
				end else if (nib == cvsd_pkg::NIB_DRIFT) begin
					mode_d = cvsd_pkg::MODE_DRIFT;
				end
			end
		end else if (id_s1 == cvsd_pkg::DETAIL_FRAME_ID) begin
			if (len_s1 >= cvsd_pkg::LEN_FULL) begin
				detail_d = byte7;
				if (byte6 == cvsd_pkg::SUB_TRACK_SPORT) begin
					mode_d = byte7[0] ? cvsd_pkg::MODE_TRACK : cvsd_pkg::MODE_SPORT;
				end
			end
		end else if (id_s1 == stab_id_q) begin
			if (len_s1 >= cvsd_pkg::LEN_STAB) begin
				if (raw == cvsd_pkg::RAW_ON) begin
					stab_d = cvsd_pkg::STAB_ON;
				end else if (raw == cvsd_pkg::RAW_OFF) begin
					stab_d = cvsd_pkg::STAB_OFF;
				end else if (raw == cvsd_pkg::RAW_SPORT) begin
					stab_d = cvsd_pkg::STAB_SPORT;
				end
			end
		end else if (id_s1 == mbtn_id_q) begin
			mcap = len_s1 >= cvsd_pkg::LEN_FULL && !payload_s1[mbtn_bit_q];
		end else if (id_s1 == body_id_q) begin
			bcap = len_s1 >= cvsd_pkg::LEN_FULL && !payload_s1[sbtn_bit_q]
				&& !payload_s1[ssbtn_bit_q];
		end else if (id_s1 == diag_id_q) begin
			fwd_d = 1'b1;
		end else begin
			fwd_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mode_q <= cvsd_pkg::MODE_NORMAL;
			stab_q <= cvsd_pkg::STAB_ON;
			detail_q <= cvsd_pkg::DETAIL_RESET;
			mtpl_q <= '0;
			btpl_q <= '0;
			mseen_q <= 1'b0;
			bseen_q <= 1'b0;
			fwd_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				mode_q <= mode_d;
				stab_q <= stab_d;
				detail_q <= detail_d;
				fwd_q <= fwd_d;
				if (mcap) begin
					mtpl_q <= payload_s1;
					mseen_q <= 1'b1;
				end
				if (bcap) begin
					btpl_q <= payload_s1;
					bseen_q <= 1'b1;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = fwd_q;
	assign m_tdata = {2'b00, bseen_q, btpl_q, mseen_q, mtpl_q, detail_q, stab_q, mode_q};

	a_mseen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mseen_q |=> mseen_q) else $error("Mode template valid flag dropped.");

	a_bseen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		bseen_q |=> bseen_q) else $error("Body template valid flag dropped.");

	a_stab_range: assert property (@(posedge clk) disable iff (!arst_n)
		stab_q != 2'd3) else $error("Stability mode out of range.");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> ($stable(mode_q) && $stable(detail_q)
		&& $stable(stab_q) && $stable(fwd_q))) else $error("State changed during stall.");

	a_input_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(id_s1)))
		else $error("Input register lost its item during stall.");

endmodule
